// ===== src/jgmd_pkg.sv =====
// jgmd_pkg: shared types and constants for the joystick gear motor drive
// no dependencies; imported by the lane, gear and top-level modules
`default_nettype none

package jgmd_pkg;

  localparam int unsigned BTN_W    = 8;
  localparam int unsigned STICK_W  = 8;
  localparam int unsigned GEAR_W   = 3;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned UP_BIT   = 0;
  localparam int unsigned DOWN_BIT = 2;

  localparam logic [STICK_W-1:0] STICK_CENTER = 8'd127;

  // one quotient bit per step
  localparam int unsigned DIV_STEPS = DUTY_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic              reverse;
    logic [DUTY_W-1:0] duty;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== src/jgmd_if.sv =====
// jgmd_in_if / jgmd_out_if: valid/ready channels for poll beats and drive results
// depends on jgmd_pkg for field widths
`default_nettype none

interface jgmd_in_if;
  import jgmd_pkg::*;
  logic               valid;
  logic               ready;
  logic [BTN_W-1:0]   button_byte;
  logic [STICK_W-1:0] right_stick;
  logic [STICK_W-1:0] left_stick;

  modport source (output valid, button_byte, right_stick, left_stick, input ready);
  modport sink   (input valid, button_byte, right_stick, left_stick, output ready);
endinterface

interface jgmd_out_if;
  import jgmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [GEAR_W-1:0] gear_now;
  logic              right_reverse;
  logic [DUTY_W-1:0] right_duty;
  logic              left_reverse;
  logic [DUTY_W-1:0] left_duty;

  modport source (output valid, gear_now, right_reverse, right_duty, left_reverse,
                  left_duty, input ready);
  modport sink   (input valid, gear_now, right_reverse, right_duty, left_reverse,
                  left_duty, output ready);
endinterface

`default_nettype wire

// ===== src/jgmd_lane.sv =====
// jgmd_lane: one stick lane, direction split and restoring divide by the gear
// depends on jgmd_pkg
`default_nettype none

module jgmd_lane
  import jgmd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire lane_ctrl_t         ctrl_i,
  input  wire logic [STICK_W-1:0] stick_i,
  input  wire logic [GEAR_W-1:0]  divisor_i,
  output      lane_res_t          res_o
);

  logic              rev_q, rev_d;
  logic [DUTY_W-1:0] quo_q, quo_d;
  logic [GEAR_W-1:0] rem_q, rem_d;
  logic [GEAR_W-1:0] div_q, div_d;
  logic [GEAR_W:0]   trial;
  logic [GEAR_W:0]   diff;

  assign trial = {rem_q, quo_q[DUTY_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rev_d = rev_q;
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    if (ctrl_i.load) begin
      div_d = divisor_i;
      rem_d = '0;
      if (stick_i >= STICK_CENTER) begin
        rev_d = 1'b0;
        quo_d = DUTY_W'(stick_i - STICK_CENTER);
      end else begin
        rev_d = 1'b1;
        quo_d = DUTY_W'(STICK_CENTER - stick_i);
      end
    end else if (ctrl_i.step) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[GEAR_W-1:0];
        quo_d = {quo_q[DUTY_W-2:0], 1'b1};
      end else begin
        rem_d = trial[GEAR_W-1:0];
        quo_d = {quo_q[DUTY_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rev_q <= rev_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.reverse = rev_q;
  assign res_o.duty    = quo_q;

endmodule

`default_nettype wire

// ===== src/jgmd_gear.sv =====
// jgmd_gear: gear selector driven by release edges of the up and down buttons
// depends on jgmd_pkg
`default_nettype none

module jgmd_gear
  import jgmd_pkg::*;
#(
  parameter int unsigned MAX_GEAR = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [BTN_W-1:0]  button_i,
  output      logic [GEAR_W-1:0] gear_o,
  output      logic [GEAR_W-1:0] divisor_o
);

  localparam logic [GEAR_W-1:0] GearMax = GEAR_W'(MAX_GEAR);
  localparam logic [GEAR_W-1:0] GearMin = GEAR_W'(1);

  logic [GEAR_W-1:0] gear_q, gear_d, gear_up;
  logic              up_q, down_q;
  logic              up_now, down_now;

  assign up_now   = button_i[UP_BIT];
  assign down_now = button_i[DOWN_BIT];

  always_comb begin
    gear_up = gear_q;
    if (!up_now && up_q) begin
      gear_up = (gear_q < GearMax) ? gear_q + GEAR_W'(1) : GearMax;
    end
    gear_d = gear_up;
    if (!down_now && down_q) begin
      gear_d = (gear_up > GearMin) ? gear_up - GEAR_W'(1) : GearMin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q <= GearMin;
      up_q   <= 1'b0;
      down_q <= 1'b0;
    end else if (accept_i) begin
      gear_q <= gear_d;
      up_q   <= up_now;
      down_q <= down_now;
    end
  end

  assign gear_o = gear_q;

  // gear never leaves range; clamp keeps the divider clear of zero anyway
  always_comb begin
    divisor_o = gear_d;
    if (gear_d < GearMin) divisor_o = GearMin;
    if (gear_d > GearMax) divisor_o = GearMax;
  end

endmodule

`default_nettype wire

// ===== src/joystick_gear_motor_drive_core.sv =====
// joystick_gear_motor_drive_core: top level, gear selector, two divider lanes, merge
// depends on jgmd_pkg, jgmd_if, jgmd_gear and jgmd_lane
`default_nettype none

// Takes one gamepad poll beat (button byte plus right and left stick bytes) and
// returns one drive beat: the current gear and, for each stick, a direction bit and
// a duty equal to the stick magnitude around center 127 divided by the gear.
// A release (1 then 0) of button bit 0 shifts up, then a release of bit 2 shifts
// down, both saturating in 1..MAX_GEAR; the gear reported is the one after the
// shift. Both sticks are divided side by side in two restoring-divider lanes that
// produce one quotient bit per cycle, so a beat goes through an accept, the divide
// steps (one per quotient bit) and a merge into the output register; the input is
// ready again the cycle after the merge. One beat is processed at a time. The
// result sits in an output register; while it waits to be taken the next poll can
// be accepted and divided, and only the merge waits for the output to free up.
module joystick_gear_motor_drive_core
  import jgmd_pkg::*;
#(
  parameter int unsigned MAX_GEAR = 5
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jgmd_in_if.sink    in_i,
  jgmd_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_MERGE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              in_fire;
  logic              merge_fire;
  lane_ctrl_t        lane_ctrl;
  lane_res_t         right_res, left_res;
  logic [GEAR_W-1:0] gear_cur, divisor;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [GEAR_W-1:0] gear_out_q;
  lane_res_t         right_out_q, left_out_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // merge only when the output register is empty or being emptied this cycle
  assign merge_fire = (state_q == ST_MERGE) && (!out_valid_q || out_o.ready);

  assign lane_ctrl.load = in_fire;
  assign lane_ctrl.step = (state_q == ST_DIV);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DIV;
          step_d  = '0;
        end
      end
      ST_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (merge_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  jgmd_gear #(
    .MAX_GEAR (MAX_GEAR)
  ) u_gear (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_fire),
    .button_i  (in_i.button_byte),
    .gear_o    (gear_cur),
    .divisor_o (divisor)
  );

  jgmd_lane u_lane_right (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .stick_i   (in_i.right_stick),
    .divisor_i (divisor),
    .res_o     (right_res)
  );

  jgmd_lane u_lane_left (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .stick_i   (in_i.left_stick),
    .divisor_i (divisor),
    .res_o     (left_res)
  );

  // merge stage: gear and both lane results into one output beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (merge_fire) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_fire) begin
      gear_out_q  <= gear_cur;
      right_out_q <= right_res;
      left_out_q  <= left_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.gear_now      = gear_out_q;
  assign out_o.right_reverse = right_out_q.reverse;
  assign out_o.right_duty    = right_out_q.duty;
  assign out_o.left_reverse  = left_out_q.reverse;
  assign out_o.left_duty     = left_out_q.duty;

endmodule

`default_nettype wire

// ===== src/jgmd_checker.sv =====
// jgmd_checker: port-level assertions for joystick_gear_motor_drive_core
// depends on jgmd_pkg; bound to the top level at the end of this file
`default_nettype none

module jgmd_checker
  import jgmd_pkg::*;
#(
  parameter int unsigned MAX_GEAR = 5
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [GEAR_W-1:0] gear_now_i,
  input wire logic              right_reverse_i,
  input wire logic [DUTY_W-1:0] right_duty_i,
  input wire logic              left_reverse_i,
  input wire logic [DUTY_W-1:0] left_duty_i
);

  // a waiting result beat is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gear_now_i)
      && $stable(right_duty_i) && $stable(left_duty_i))
    else $error("result beat dropped or changed while stalled");

  // gear stays in range
  a_gear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gear_now_i >= GEAR_W'(1) && gear_now_i <= GEAR_W'(MAX_GEAR))
    else $error("gear out of range");

  // one poll at a time: after an accept the input is busy
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while dividing");

  // reverse magnitude is at most 127, forward at most 128
  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> right_duty_i <= (right_reverse_i ? 8'd127 : 8'd128)
      && left_duty_i <= (left_reverse_i ? 8'd127 : 8'd128))
    else $error("duty exceeds stick magnitude");

  // a gear of two or more at least halves the duty
  a_duty_geared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gear_now_i >= GEAR_W'(2) |-> right_duty_i <= 8'd64
      && left_duty_i <= 8'd64)
    else $error("duty not divided by gear");

endmodule

bind joystick_gear_motor_drive_core jgmd_checker #(
  .MAX_GEAR (MAX_GEAR)
) u_jgmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .gear_now_i      (out_o.gear_now),
  .right_reverse_i (out_o.right_reverse),
  .right_duty_i    (out_o.right_duty),
  .left_reverse_i  (out_o.left_reverse),
  .left_duty_i     (out_o.left_duty)
);

`default_nettype wire
